@@ rtl/hna_pkg.sv @@
// Package: shared types and command codes for the hex neighbourhood address generator.
package hna_pkg;

  localparam logic [1:0] CMD_DISK     = 2'd0;
  localparam logic [1:0] CMD_RING     = 2'd1;
  localparam logic [1:0] CMD_ADJACENT = 2'd2;

  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam int CW = 12;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [8:0] cq;
    logic [7:0]        cr;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic       hit;
    logic       end_walk;
    logic [7:0] col;
    logic [7:0] row;
  } hit_t;

  typedef struct packed {
    logic       strobe;
    logic       valid_res;
    logic [7:0] column;
    logic [7:0] row_index;
    logic       last;
  } res_t;

endpackage

@@ rtl/hna_walker.sv @@
// Walk sequencer: holds the item and steps one candidate offset pair per cycle.
module hna_walker #(
  parameter int MAX_RANGE = 4,
  parameter int RW = $clog2(MAX_RANGE + 1),
  parameter int OW = RW + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_command,
  input  logic signed [8:0]    in_center_q,
  input  logic [7:0]           in_center_r,
  input  logic [3:0]           in_reach,
  input  logic                 done,
  output logic                 busy,
  output hna_pkg::item_t       item,
  output logic [RW-1:0]        range,
  output logic                 cand_valid,
  output logic signed [OW-1:0] cand_dq,
  output logic signed [OW-1:0] cand_ds,
  output logic                 cand_end
);

  logic                 busy_r, busy_nxt;
  logic                 act_r, act_nxt;
  hna_pkg::item_t       item_r;
  logic [RW-1:0]        range_r;
  logic signed [OW-1:0] dq_r, dq_nxt;
  logic signed [OW-1:0] ds_r, ds_nxt;
  logic [RW-1:0]        range_in;
  logic signed [OW-1:0] pos_r, neg_r, neg_in;
  logic                 accept;

  assign accept = start && !busy_r;

  always_comb begin
    if (in_command == hna_pkg::CMD_ADJACENT) begin
      range_in = RW'(1);
    end else if (32'(in_reach) > MAX_RANGE) begin
      range_in = RW'(MAX_RANGE);
    end else begin
      range_in = RW'(in_reach);
    end
  end

  assign neg_in = -$signed({1'b0, range_in});
  assign pos_r  = $signed({1'b0, range_r});
  assign neg_r  = -pos_r;
  assign cand_end = (dq_r == pos_r) && (ds_r == pos_r);

  always_comb begin
    busy_nxt = busy_r;
    act_nxt  = act_r;
    dq_nxt   = dq_r;
    ds_nxt   = ds_r;
    if (accept) begin
      busy_nxt = 1'b1;
      act_nxt  = 1'b1;
      dq_nxt   = neg_in;
      ds_nxt   = neg_in;
    end else begin
      if (done) begin
        busy_nxt = 1'b0;
      end
      if (act_r) begin
        if (cand_end) begin
          act_nxt = 1'b0;
        end else if (ds_r == pos_r) begin
          ds_nxt = neg_r;
          dq_nxt = dq_r + OW'(1);
        end else begin
          ds_nxt = ds_r + OW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      act_r  <= 1'b0;
      dq_r   <= '0;
      ds_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      act_r  <= act_nxt;
      dq_r   <= dq_nxt;
      ds_r   <= ds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd <= in_command;
      item_r.cq  <= in_center_q;
      item_r.cr  <= in_center_r;
      range_r    <= range_in;
    end
  end

  assign busy       = busy_r;
  assign item       = item_r;
  assign range      = range_r;
  assign cand_valid = act_r;
  assign cand_dq    = dq_r;
  assign cand_ds    = ds_r;

endmodule

@@ rtl/hna_filter.sv @@
// Filter pipeline: selects offsets by command, maps to tiles and checks map bounds.
module hna_filter #(
  parameter int MAX_RANGE = 4,
  parameter int RW = $clog2(MAX_RANGE + 1),
  parameter int OW = RW + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hna_pkg::item_t       item,
  input  logic [RW-1:0]        range,
  input  logic [9:0]           cols_lim,
  input  logic [9:0]           rows_lim,
  input  logic                 cand_valid,
  input  logic signed [OW-1:0] cand_dq,
  input  logic signed [OW-1:0] cand_ds,
  input  logic                 cand_end,
  output hna_pkg::hit_t        hit
);

  localparam int DW = OW + 2;
  localparam int CW = hna_pkg::CW;

  logic signed [DW-1:0] dq_w, ds_w, dr_w, rng_w;
  logic signed [DW-1:0] adq, ads, adr, dist2;
  logic                 in_rng, take;
  logic signed [CW-1:0] row1_c;

  logic                 v1_r, keep1_r, end1_r;
  logic signed [OW-1:0] dq1_r;
  logic signed [CW-1:0] row1_r;

  logic                 row_ok;
  logic signed [CW-1:0] col2_c;
  logic                 v2_r, keep2_r, end2_r;
  logic signed [CW-1:0] col2_r, row2_r;

  logic                 col_ok;
  logic                 hit_v_r, hit_hit_r, hit_end_r;
  logic [7:0]           hit_col_r, hit_row_r;

  assign dq_w  = DW'(cand_dq);
  assign ds_w  = DW'(cand_ds);
  assign dr_w  = -(dq_w + ds_w);
  assign rng_w = $signed(DW'(range));
  assign adq   = dq_w[DW-1] ? -dq_w : dq_w;
  assign ads   = ds_w[DW-1] ? -ds_w : ds_w;
  assign adr   = dr_w[DW-1] ? -dr_w : dr_w;
  assign dist2 = adq + ads + adr;
  assign in_rng = (dr_w >= -rng_w) && (dr_w <= rng_w);

  always_comb begin
    unique case (item.cmd)
      hna_pkg::CMD_DISK:     take = 1'b1;
      hna_pkg::CMD_RING:     take = (dist2 == (rng_w <<< 1));
      hna_pkg::CMD_ADJACENT: take = (dist2 != '0);
      default:               take = 1'b0;
    endcase
  end

  assign row1_c = $signed(CW'({1'b0, item.cr})) + CW'(dr_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= cand_valid;
    end
  end

  always_ff @(posedge clk) begin
    keep1_r <= in_rng && take;
    end1_r  <= cand_end;
    dq1_r   <= cand_dq;
    row1_r  <= row1_c;
  end

  assign row_ok = (row1_r >= 0) && (row1_r < $signed(CW'(rows_lim)));
  assign col2_c = CW'(item.cq) + CW'(dq1_r) + (row1_r >>> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    keep2_r <= keep1_r && row_ok;
    end2_r  <= end1_r;
    col2_r  <= col2_c;
    row2_r  <= row1_r;
  end

  assign col_ok = (col2_r >= 0) && (col2_r < $signed(CW'(cols_lim)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_v_r <= 1'b0;
    end else begin
      hit_v_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    hit_hit_r <= keep2_r && col_ok;
    hit_end_r <= end2_r;
    hit_col_r <= col2_r[7:0];
    hit_row_r <= row2_r[7:0];
  end

  assign hit = {hit_v_r, hit_hit_r, hit_end_r, hit_col_r, hit_row_r};

endmodule

@@ rtl/hna_emit.sv @@
// Result formatter: holds one tile back so that the final beat carries last.
module hna_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  hna_pkg::hit_t hit,
  output logic          done,
  output hna_pkg::res_t res
);

  logic          pend_v_r;
  logic [7:0]    pend_col_r, pend_row_r;
  logic          flush_r;
  logic          strobe_r, vres_r, last_r;
  logic [7:0]    col_r, row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      flush_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (flush_r) begin
        flush_r  <= 1'b0;
        pend_v_r <= 1'b0;
        strobe_r <= 1'b1;
      end else if (hit.valid) begin
        if (hit.hit) begin
          pend_v_r <= 1'b1;
          strobe_r <= pend_v_r;
        end
        flush_r <= hit.end_walk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flush_r) begin
      vres_r <= pend_v_r;
      col_r  <= pend_v_r ? pend_col_r : 8'd0;
      row_r  <= pend_v_r ? pend_row_r : 8'd0;
      last_r <= 1'b1;
    end else begin
      vres_r <= 1'b1;
      col_r  <= pend_col_r;
      row_r  <= pend_row_r;
      last_r <= 1'b0;
    end
    if (!flush_r && hit.valid && hit.hit) begin
      pend_col_r <= hit.col;
      pend_row_r <= hit.row;
    end
  end

  assign done = flush_r;
  assign res  = {strobe_r, vres_r, col_r, row_r, last_r};

endmodule

@@ rtl/hex_neighbourhood_address_gen.sv @@
// Top level: hex neighbourhood address generator with configuration registers.
//
// Input: an item (command, centre q/r, reach) is taken at a clock edge with
// start high and busy low. busy stays high until the item's final result beat
// has been produced; one item is in work at a time.
// Output: each result beat is on the out_ ports for one cycle with out_strobe
// high. Tiles come in walk order (dq outer, ds inner); out_last marks the final
// beat. An item with no in-bounds tile gives one beat with out_valid_res low.
// Timing: the walker steps one offset pair per cycle over all (2*r+1)^2 pairs,
// r the clamped range (81 pairs at range 4); each pair then passes through the
// filter and formatter pipeline, and busy drops once the last pair has left it.
// The final beat is on the ports in the first cycle with busy low, and the next
// item can be taken from then on.
// Configuration: cfg_we writes map_columns (index 0) or map_rows (index 1)
// from cfg_data; write only while busy is low.
// Reset: rst_n low at a clock edge empties the walk and pipeline and sets
// both map sizes to 256. The receiver cannot stall; beats are never held.
module hex_neighbourhood_address_gen #(
  parameter int MAX_RANGE   = 4,
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic signed [8:0] in_center_q,
  input  logic [7:0]        in_center_r,
  input  logic [3:0]        in_reach,
  output logic              out_strobe,
  output logic              out_valid_res,
  output logic [7:0]        out_column,
  output logic [7:0]        out_row_index,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [8:0]        cfg_data
);

  localparam int RW = $clog2(MAX_RANGE + 1);
  localparam int OW = RW + 1;

  logic [8:0]           cols_r, rows_r;
  logic [9:0]           cols_lim, rows_lim;
  hna_pkg::item_t       item;
  logic [RW-1:0]        range;
  logic                 cand_valid, cand_end;
  logic signed [OW-1:0] cand_dq, cand_ds;
  hna_pkg::hit_t        hit;
  hna_pkg::res_t        res;
  logic                 done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 9'd256;
      rows_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hna_pkg::CFG_COLUMNS: cols_r <= cfg_data;
        hna_pkg::CFG_ROWS:    rows_r <= cfg_data;
        default:              ;
      endcase
    end
  end

  assign cols_lim = (32'(cols_r) > MAX_COLUMNS) ? 10'(MAX_COLUMNS) : {1'b0, cols_r};
  assign rows_lim = (32'(rows_r) > MAX_ROWS) ? 10'(MAX_ROWS) : {1'b0, rows_r};

  hna_walker #(
    .MAX_RANGE (MAX_RANGE),
    .RW        (RW),
    .OW        (OW)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_command  (in_command),
    .in_center_q (in_center_q),
    .in_center_r (in_center_r),
    .in_reach    (in_reach),
    .done        (done),
    .busy        (busy),
    .item        (item),
    .range       (range),
    .cand_valid  (cand_valid),
    .cand_dq     (cand_dq),
    .cand_ds     (cand_ds),
    .cand_end    (cand_end)
  );

  hna_filter #(
    .MAX_RANGE (MAX_RANGE),
    .RW        (RW),
    .OW        (OW)
  ) u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .range      (range),
    .cols_lim   (cols_lim),
    .rows_lim   (rows_lim),
    .cand_valid (cand_valid),
    .cand_dq    (cand_dq),
    .cand_ds    (cand_ds),
    .cand_end   (cand_end),
    .hit        (hit)
  );

  hna_emit u_emit (
    .clk   (clk),
    .rst_n (rst_n),
    .hit   (hit),
    .done  (done),
    .res   (res)
  );

  assign out_strobe    = res.strobe;
  assign out_valid_res = res.valid_res;
  assign out_column    = res.column;
  assign out_row_index = res.row_index;
  assign out_last      = res.last;

endmodule

@@ tb/sv/hex_neighbourhood_address_gen_tb.sv @@
// Testbench: self-checking stimulus and tile prediction for the hex neighbourhood address generator.
module hex_neighbourhood_address_gen_tb;

  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam int         WALK_LIMIT      = 4;
  localparam int         GRID_LIMIT      = 256;
  localparam int         PHASES          = 7;
  localparam int         PHASE_ITEMS     = 42;

  class tile_scoreboard;
    int    map_cols = 256;
    int    map_rows = 256;
    int    mismatches = 0;
    hna_pkg::res_t expected_tiles[$];

    function void set_map(logic idx, logic [8:0] data);
      if (idx == hna_pkg::CFG_COLUMNS) begin
        map_cols = int'(data);
      end else begin
        map_rows = int'(data);
      end
    endfunction

    function int pending();
      return expected_tiles.size();
    endfunction

    function int abs_of(int v);
      return (v < 0) ? -v : v;
    endfunction

    // Walk dq outer, ds inner and queue every in-bounds tile the command selects, or one empty final beat if none.
    function void note_centre(logic [1:0] cmd, logic signed [8:0] q, logic [7:0] r,
                              logic [3:0] reach);
      int   span;
      int   cols;
      int   rows;
      int   dr;
      int   hex_dist;
      int   row;
      int   col;
      int   hits;
      bit   take;
      hna_pkg::res_t beat;
      span = (reach > WALK_LIMIT) ? WALK_LIMIT : int'(reach);
      if (cmd == hna_pkg::CMD_ADJACENT) begin
        span = 1;
      end
      cols = (map_cols > GRID_LIMIT) ? GRID_LIMIT : map_cols;
      rows = (map_rows > GRID_LIMIT) ? GRID_LIMIT : map_rows;
      hits = 0;
      for (int dq = -span; dq <= span; dq++) begin
        for (int ds = -span; ds <= span; ds++) begin
          dr = -dq - ds;
          if (dr < -span || dr > span) continue;
          hex_dist = abs_of(dq) + abs_of(ds) + abs_of(dr);
          case (cmd)
            hna_pkg::CMD_DISK:     take = 1'b1;
            hna_pkg::CMD_RING:     take = (hex_dist == 2 * span);
            hna_pkg::CMD_ADJACENT: take = (hex_dist != 0);
            default:               take = 1'b0;
          endcase
          if (!take) continue;
          row = int'(r) + dr;
          if (row < 0 || row >= rows) continue;
          col = int'(q) + dq + row / 2;
          if (col < 0 || col >= cols) continue;
          beat.strobe    = 1'b1;
          beat.valid_res = 1'b1;
          beat.column    = col[7:0];
          beat.row_index = row[7:0];
          beat.last      = 1'b0;
          expected_tiles.push_back(beat);
          hits++;
        end
      end
      if (hits == 0) begin
        beat = '0;
        beat.strobe = 1'b1;
        beat.last   = 1'b1;
        expected_tiles.push_back(beat);
      end else begin
        expected_tiles[expected_tiles.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_tile(logic v, logic [7:0] col, logic [7:0] row, logic last);
      hna_pkg::res_t want;
      if (expected_tiles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: valid %0b col %0d row %0d last %0b", v, col, row, last);
        end
        return;
      end
      want = expected_tiles.pop_front();
      if (want.valid_res !== v || want.column !== col || want.row_index !== row ||
          want.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tile mismatch: expected valid %0b col %0d row %0d last %0b,",
                   want.valid_res, want.column, want.row_index, want.last);
          $display("  got valid %0b col %0d row %0d last %0b", v, col, row, last);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_command = '0;
  logic signed [8:0] in_center_q = '0;
  logic [7:0]        in_center_r = '0;
  logic [3:0]        in_reach = '0;
  logic              out_strobe;
  logic              out_valid_res;
  logic [7:0]        out_column;
  logic [7:0]        out_row_index;
  logic              out_last;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [8:0]        cfg_data = '0;

  tile_scoreboard sb;

  hex_neighbourhood_address_gen u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_center_q   (in_center_q),
    .in_center_r   (in_center_r),
    .in_reach      (in_reach),
    .out_strobe    (out_strobe),
    .out_valid_res (out_valid_res),
    .out_column    (out_column),
    .out_row_index (out_row_index),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_tile(out_valid_res, out_column, out_row_index, out_last);
    end
  end

  function int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  // Hold start until the beat is taken; drop start only when a gap follows.
  task automatic send_item(logic [1:0] cmd, int q, int r, int reach, int gap);
    start       <= 1'b1;
    in_command  <= cmd;
    in_center_q <= q[8:0];
    in_center_r <= r[7:0];
    in_reach    <= reach[3:0];
    do @(posedge clk); while (busy);
    sb.note_centre(cmd, q[8:0], r[7:0], reach[3:0]);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained(int settle);
    int spin;
    spin = 0;
    while ((sb.pending() != 0 || busy) && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_map_size(int cols, int rows);
    cfg_we    <= 1'b1;
    cfg_index <= hna_pkg::CFG_COLUMNS;
    cfg_data  <= cols[8:0];
    @(posedge clk);
    sb.set_map(hna_pkg::CFG_COLUMNS, cols[8:0]);
    cfg_index <= hna_pkg::CFG_ROWS;
    cfg_data  <= rows[8:0];
    @(posedge clk);
    sb.set_map(hna_pkg::CFG_ROWS, rows[8:0]);
    cfg_we <= 1'b0;
  endtask

  // Aim most centres at the map so tiles land in bounds; leave some fully random.
  task automatic run_random(int n, int cols, int rows, bit no_idle);
    int         eff_cols;
    int         eff_rows;
    int         q;
    int         r;
    int         reach;
    int         gap;
    bit         pause;
    logic [1:0] cmd;
    eff_cols = (cols > GRID_LIMIT) ? GRID_LIMIT : cols;
    eff_rows = (rows > GRID_LIMIT) ? GRID_LIMIT : rows;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4) begin
        cmd = CMD_UNUSED;
      end else begin
        cmd = 2'($urandom_range(0, 2));
      end
      reach = $urandom_range(0, 15);
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, (eff_rows + 3 > 255) ? 255 : eff_rows + 3);
        q = int'($urandom_range(0, eff_cols + 3)) - r / 2;
        if (q > 255) q = 255;
      end else begin
        q = $urandom_range(0, 511);
        r = $urandom_range(0, 255);
      end
      pause = ($urandom_range(0, 29) == 0) || (i == n - 1);
      gap = no_idle ? 0 : pick_gap();
      if (pause && gap == 0) gap = 1;
      send_item(cmd, q, r, reach, gap);
      if (pause) wait_drained(0);
    end
  endtask

  initial begin
    int cols_set[PHASES];
    int rows_set[PHASES];
    int cols;
    int rows;
    cols_set = '{256, 1, 511, 0, 37, 256, 0};
    rows_set = '{256, 1, 300, 100, 0, 9, 0};
    sb = new;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(hna_pkg::CMD_DISK,     10,  10,  0, pick_gap());
    send_item(hna_pkg::CMD_DISK,     100, 100, 4, pick_gap());
    send_item(hna_pkg::CMD_DISK,     50,  60,  15, pick_gap());
    send_item(hna_pkg::CMD_RING,     20,  20,  0, pick_gap());
    send_item(hna_pkg::CMD_RING,     80,  40,  4, pick_gap());
    send_item(hna_pkg::CMD_RING,     -30, 90,  2, pick_gap());
    send_item(hna_pkg::CMD_RING,     -100, 200, 9, pick_gap());
    send_item(hna_pkg::CMD_ADJACENT, 5,   5,   0, pick_gap());
    send_item(hna_pkg::CMD_ADJACENT, 7,   3,   15, pick_gap());
    send_item(CMD_UNUSED,            40,  40,  3, pick_gap());
    send_item(hna_pkg::CMD_DISK,     0,   0,   4, pick_gap());
    send_item(hna_pkg::CMD_DISK,     -256, 255, 4, pick_gap());
    send_item(hna_pkg::CMD_DISK,     255, 255, 4, pick_gap());
    send_item(hna_pkg::CMD_DISK,     -128, 255, 3, pick_gap());
    send_item(hna_pkg::CMD_ADJACENT, -1,  0,   1, pick_gap());
    send_item(hna_pkg::CMD_DISK,     255, 0,   1, pick_gap());
    send_item(hna_pkg::CMD_DISK,     -256, 0,  2, pick_gap());
    send_item(hna_pkg::CMD_RING,     -2,  4,   1, 1);
    wait_drained(6);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        cols = $urandom_range(0, 511);
        rows = $urandom_range(0, 511);
      end else begin
        cols = cols_set[ph];
        rows = rows_set[ph];
      end
      write_map_size(cols, rows);
      run_random(PHASE_ITEMS, cols, rows, ph % 3 == 1);
      wait_drained(6);
    end

    wait_drained(10);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule
